[rtl/tpcm_pkg.sv]
// Shared types and codes of the token prefix cache matcher.
`timescale 1ns / 1ps
`default_nettype none
package tpcm_pkg;

  localparam int TOKEN_W = 32;
  localparam int COUNT_W = 9;
  localparam int POS_W   = 32;
  localparam int ENTRY_W = 3;
  localparam int SLOT_W  = 3;

  localparam logic [1:0] REQ_TOKEN   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_ERASE   = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  localparam logic [1:0] KIND_MATCH = 2'd0;
  localparam logic [1:0] KIND_POS   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [TOKEN_W-1:0] token_id;
    logic               token_valid;
    logic               last_token;
    logic [SLOT_W-1:0]  batch_slot;
  } tpcm_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         error_code;
    logic [ENTRY_W-1:0] entry_index;
    logic [COUNT_W-1:0] cached_count;
    logic [COUNT_W-1:0] uncached_count;
    logic [POS_W-1:0]   position;
  } tpcm_out_t;

endpackage
`default_nettype wire

[rtl/token_prefix_cache_matcher.sv]
// Top level of the token prefix cache matcher: sequencer, entry tables and queues.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel: drive in_item and raise start; a transaction is taken at an edge
//   where start is high and busy is low. A request token (req_type 0) that is not
//   the last one is stored and gives no result; busy stays low.
//   The last token starts the match: every present queued entry is walked start
//   by start through the ring memory read port (S_RD) and the shared comparator
//   (S_CMP). Tokens are then copied into the chosen ring on the way out. Release
//   and erase move the batch entries back to the queue in S_REL, then answer. A
//   position query reads its entry in S_QRY; an empty slot is answered from idle.
//   Result channel: out_valid pulses for one cycle with out_item; the receiver
//   cannot stall it, so it must take every result when shown.
//   Reset (rst_n low, synchronous) empties all entries, puts every entry in the
//   queue in index order, empties the batch and drops any partly loaded request.
//   Ring contents need no clearing: no entry is read before it is written.
module token_prefix_cache_matcher #(
  parameter int NUM_ENTRIES = 8,
  parameter int RING_TOKENS = 256,
  parameter int MAX_TOKENS  = 256,
  parameter int TOKEN_BITS  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tpcm_pkg::tpcm_in_t  in_item,
  output logic                     out_valid,
  output tpcm_pkg::tpcm_out_t      out_item
);

  localparam int EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW  = $clog2(NUM_ENTRIES + 1);
  localparam int RW  = $clog2(RING_TOKENS);
  localparam int NW  = $clog2(MAX_TOKENS + 1);
  localparam int AW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int RAW = $clog2(NUM_ENTRIES * RING_TOKENS);
  localparam int SW  = ((RW > NW) ? RW : NW) + 1;
  localparam int TB  = TOKEN_BITS;

  localparam logic [RW:0]   RING_X = (RW + 1)'(RING_TOKENS);
  localparam logic [RW-1:0] RLAST  = RW'(RING_TOKENS - 1);
  localparam logic [NW-1:0] MAXN   = NW'(MAX_TOKENS);
  localparam logic [CW-1:0] NUMC   = CW'(NUM_ENTRIES);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_ENT   = 11'b000_0000_0100,
    S_RD    = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_DEC   = 11'b000_0010_0000,
    S_CP_RD = 11'b000_0100_0000,
    S_CP_WR = 11'b000_1000_0000,
    S_FIN   = 11'b001_0000_0000,
    S_REL   = 11'b010_0000_0000,
    S_QRY   = 11'b100_0000_0000
  } state_t;

  function automatic logic [RW-1:0] ring_dist(input logic [RW-1:0] from,
                                              input logic [RW-1:0] to);
    logic [RW:0] d;
    if (to >= from) begin
      d = {1'b0, to} - {1'b0, from};
    end else begin
      d = {1'b0, to} + RING_X - {1'b0, from};
    end
    return d[RW-1:0];
  endfunction

  function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] x);
    return (x == RLAST) ? '0 : x + 1'b1;
  endfunction

  state_t state_r, state_nxt;

  // entry tables and queues
  logic          present_r  [NUM_ENTRIES];
  logic          present_nxt[NUM_ENTRIES];
  logic [RW-1:0] start_r    [NUM_ENTRIES];
  logic [RW-1:0] start_nxt  [NUM_ENTRIES];
  logic [RW-1:0] stop_r     [NUM_ENTRIES];
  logic [RW-1:0] stop_nxt   [NUM_ENTRIES];
  logic [RW-1:0] fill_r     [NUM_ENTRIES];
  logic [RW-1:0] fill_nxt   [NUM_ENTRIES];
  logic [31:0]   seq_r      [NUM_ENTRIES];
  logic [31:0]   seq_nxt    [NUM_ENTRIES];
  logic [EW-1:0] fo_r       [NUM_ENTRIES];
  logic [EW-1:0] fo_nxt     [NUM_ENTRIES];
  logic [EW-1:0] bl_r       [NUM_ENTRIES];
  logic [EW-1:0] bl_nxt     [NUM_ENTRIES];
  logic [CW-1:0] fc_r, fc_nxt, bc_r, bc_nxt;

  // request loading
  logic [NW-1:0] len_r, len_nxt, v_r, v_nxt, trail_r, trail_nxt;
  logic          vrun_r, vrun_nxt, ovf_r, ovf_nxt;

  // sequencer working registers
  logic [CW-1:0] k_r, k_nxt;
  logic [EW-1:0] ent_r, ent_nxt, bestk_r, bestk_nxt;
  logic [RW-1:0] bi_r, bi_nxt, ii_r, ii_nxt, bestbi_r, bestbi_nxt;
  logic [NW-1:0] i_r, i_nxt, best_r, best_nxt, lim_r, lim_nxt;
  logic          found_r, found_nxt, erase_r, erase_nxt;

  logic                out_valid_r, out_valid_nxt;
  tpcm_pkg::tpcm_out_t out_r, out_nxt;

  // memories
  logic           req_we;
  logic [TB:0]    req_rdata;
  logic [RAW-1:0] ring_addr;
  logic           ring_we;
  logic [TB-1:0]  ring_rdata;

  tpcm_ram #(.WIDTH(TB + 1), .DEPTH(MAX_TOKENS)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (len_r[AW-1:0]),
    .wdata ({in_item.token_valid, in_item.token_id[TB-1:0]}),
    .raddr (i_r[AW-1:0]),
    .rdata (req_rdata)
  );

  assign ring_addr = RAW'(ent_r) * RAW'(RING_TOKENS) + RAW'(ii_r);

  tpcm_ram #(.WIDTH(TB), .DEPTH(NUM_ENTRIES * RING_TOKENS)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_addr),
    .wdata (req_rdata[TB-1:0]),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  always_comb begin
    logic [EW-1:0] e;
    logic [EW-1:0] p;
    logic          eq;
    logic [NW-1:0] run_len;
    logic [NW-1:0] cached_v;
    logic [NW:0]   need;
    logic [NW:0]   unc;
    logic [SW-1:0] fsum;
    logic [RW-1:0] qd;
    logic          clr_req;

    state_nxt     = state_r;
    present_nxt   = present_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    fill_nxt      = fill_r;
    seq_nxt       = seq_r;
    fo_nxt        = fo_r;
    bl_nxt        = bl_r;
    fc_nxt        = fc_r;
    bc_nxt        = bc_r;
    len_nxt       = len_r;
    v_nxt         = v_r;
    trail_nxt     = trail_r;
    vrun_nxt      = vrun_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    ent_nxt       = ent_r;
    bestk_nxt     = bestk_r;
    bi_nxt        = bi_r;
    ii_nxt        = ii_r;
    bestbi_nxt    = bestbi_r;
    i_nxt         = i_r;
    best_nxt      = best_r;
    lim_nxt       = lim_r;
    found_nxt     = found_r;
    erase_nxt     = erase_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    req_we        = 1'b0;
    ring_we       = 1'b0;
    clr_req       = 1'b0;
    e             = '0;
    p             = '0;
    eq            = 1'b0;
    run_len       = '0;
    cached_v      = '0;
    need          = '0;
    unc           = '0;
    fsum          = '0;
    qd            = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.req_type)
            tpcm_pkg::REQ_TOKEN: begin
              if (len_r < MAXN) begin
                req_we  = 1'b1;
                len_nxt = len_r + 1'b1;
                if (vrun_r && in_item.token_valid) begin
                  v_nxt = v_r + 1'b1;
                end
                if (!in_item.token_valid) begin
                  vrun_nxt = 1'b0;
                end
                trail_nxt = in_item.token_valid ? '0 : trail_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_item.last_token) begin
                state_nxt = S_CHECK;
              end
            end
            tpcm_pkg::REQ_RELEASE, tpcm_pkg::REQ_ERASE: begin
              erase_nxt = (in_item.req_type == tpcm_pkg::REQ_ERASE);
              k_nxt     = '0;
              state_nxt = S_REL;
            end
            tpcm_pkg::REQ_QUERY: begin
              if (32'(in_item.batch_slot) >= 32'(bc_r)) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
                out_nxt.result_kind = tpcm_pkg::KIND_POS;
                out_nxt.error_code  = tpcm_pkg::ERR_EMPTY;
              end else begin
                ent_nxt   = bl_r[EW'(in_item.batch_slot)];
                state_nxt = S_QRY;
              end
            end
            default: ;
          endcase
        end
      end

      S_CHECK: begin
        if (ovf_r || (32'(v_r) > 32'(RING_TOKENS))) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.error_code = tpcm_pkg::ERR_LONG;
          clr_req   = 1'b1;
          state_nxt = S_IDLE;
        end else if (fc_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.error_code = tpcm_pkg::ERR_EMPTY;
          clr_req   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          best_nxt  = '0;
          bestk_nxt = '0;
          k_nxt     = '0;
          // a request whose first token is masked cannot match anything
          state_nxt = (v_r == '0) ? S_DEC : S_ENT;
        end
      end

      S_ENT: begin
        if (k_r >= fc_r) begin
          state_nxt = S_DEC;
        end else begin
          e = fo_r[k_r[EW-1:0]];
          if (!present_r[e]) begin
            k_nxt = k_r + 1'b1;
          end else begin
            ent_nxt   = e;
            bi_nxt    = start_r[e];
            ii_nxt    = start_r[e];
            i_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        eq = (ring_rdata == req_rdata[TB-1:0]);
        if (eq && !((ii_r == stop_r[ent_r]) || (i_r + 1'b1 == v_r))) begin
          i_nxt     = i_r + 1'b1;
          ii_nxt    = ring_next(ii_r);
          state_nxt = S_RD;
        end else begin
          run_len = eq ? i_r + 1'b1 : i_r;
          // strict compare: the first best start and entry win
          if (run_len > best_r) begin
            best_nxt   = run_len;
            bestk_nxt  = k_r[EW-1:0];
            bestbi_nxt = bi_r;
          end
          if (bi_r == stop_r[ent_r]) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_ENT;
          end else begin
            bi_nxt    = ring_next(bi_r);
            ii_nxt    = ring_next(bi_r);
            i_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end

      S_DEC: begin
        p = (best_r != '0) ? bestk_r : '0;
        e = fo_r[p];
        ent_nxt   = e;
        found_nxt = (best_r != '0);
        for (int j = 0; j < NUM_ENTRIES - 1; j++) begin
          if (j >= int'(p)) begin
            fo_nxt[j] = fo_r[j + 1];
          end
        end
        fc_nxt = fc_r - 1'b1;
        if (bc_r < NUMC) begin
          bl_nxt[bc_r[EW-1:0]] = e;
          bc_nxt = bc_r + 1'b1;
        end
        i_nxt = '0;
        if (best_r != '0) begin
          seq_nxt[e]   = seq_r[e] + 32'(ring_dist(start_r[e], bestbi_r));
          start_nxt[e] = bestbi_r;
          ii_nxt       = bestbi_r;
          lim_nxt      = v_r;
        end else begin
          present_nxt[e] = 1'b1;
          start_nxt[e]   = '0;
          stop_nxt[e]    = '0;
          seq_nxt[e]     = '0;
          ii_nxt         = '0;
          lim_nxt        = (32'(len_r) > 32'(RING_TOKENS)) ? NW'(RING_TOKENS) : len_r;
        end
        state_nxt = S_CP_RD;
      end

      S_CP_RD: begin
        state_nxt = (i_r >= lim_r) ? S_FIN : S_CP_WR;
      end

      S_CP_WR: begin
        // token 0 is always stored; later tokens stop at the first masked one
        if ((i_r != '0) && !req_rdata[TB]) begin
          state_nxt = S_FIN;
        end else begin
          ring_we         = 1'b1;
          stop_nxt[ent_r] = ii_r;
          i_nxt           = i_r + 1'b1;
          ii_nxt          = ring_next(ii_r);
          state_nxt       = S_CP_RD;
        end
      end

      S_FIN: begin
        if (found_r) begin
          if (best_r < v_r) begin
            fsum = SW'(bestbi_r) + SW'(best_r);
            if (fsum >= SW'(RING_TOKENS)) begin
              fsum = fsum - SW'(RING_TOKENS);
            end
            fill_nxt[ent_r] = fsum[RW-1:0];
            cached_v        = best_r;
          end else begin
            // whole prefix matched: keep one token uncached
            fill_nxt[ent_r] = stop_r[ent_r];
            cached_v        = best_r - 1'b1;
          end
        end else begin
          fill_nxt[ent_r] = '0;
          cached_v        = '0;
        end
        need = {1'b0, cached_v} + {1'b0, trail_r};
        unc  = ({1'b0, len_r} >= need) ? {1'b0, len_r} - need : '0;
        out_valid_nxt          = 1'b1;
        out_nxt.result_kind    = tpcm_pkg::KIND_MATCH;
        out_nxt.error_code     = tpcm_pkg::ERR_NONE;
        out_nxt.entry_index    = (tpcm_pkg::ENTRY_W)'(ent_r);
        out_nxt.cached_count   = (tpcm_pkg::COUNT_W)'(cached_v);
        out_nxt.uncached_count = (tpcm_pkg::COUNT_W)'(unc);
        out_nxt.position       = seq_r[ent_r] + 32'(cached_v);
        clr_req   = 1'b1;
        state_nxt = S_IDLE;
      end

      S_REL: begin
        // move the batch back to the queue tail, one entry per cycle
        if ((k_r < bc_r) && (fc_r < NUMC)) begin
          fo_nxt[fc_r[EW-1:0]] = bl_r[k_r[EW-1:0]];
          fc_nxt = fc_r + 1'b1;
          k_nxt  = k_r + 1'b1;
        end else begin
          bc_nxt = '0;
          if (erase_r) begin
            for (int j = 0; j < NUM_ENTRIES; j++) begin
              present_nxt[j] = 1'b0;
            end
          end
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.result_kind = tpcm_pkg::KIND_DONE;
          state_nxt           = S_IDLE;
        end
      end

      S_QRY: begin
        qd = ring_dist(start_r[ent_r], fill_r[ent_r]);
        out_valid_nxt          = 1'b1;
        out_nxt.result_kind    = tpcm_pkg::KIND_POS;
        out_nxt.error_code     = tpcm_pkg::ERR_NONE;
        out_nxt.entry_index    = (tpcm_pkg::ENTRY_W)'(ent_r);
        out_nxt.cached_count   = (tpcm_pkg::COUNT_W)'(qd);
        out_nxt.uncached_count = '0;
        out_nxt.position       = seq_r[ent_r] + 32'(qd);
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clr_req) begin
      len_nxt   = '0;
      v_nxt     = '0;
      trail_nxt = '0;
      vrun_nxt  = 1'b1;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= NUMC;
      bc_r        <= '0;
      len_r       <= '0;
      v_r         <= '0;
      trail_r     <= '0;
      vrun_r      <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        present_r[j] <= 1'b0;
        fo_r[j]      <= EW'(j);
      end
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      bc_r        <= bc_nxt;
      len_r       <= len_nxt;
      v_r         <= v_nxt;
      trail_r     <= trail_nxt;
      vrun_r      <= vrun_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      present_r   <= present_nxt;
      fo_r        <= fo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    stop_r   <= stop_nxt;
    fill_r   <= fill_nxt;
    seq_r    <= seq_nxt;
    bl_r     <= bl_nxt;
    k_r      <= k_nxt;
    ent_r    <= ent_nxt;
    bestk_r  <= bestk_nxt;
    bi_r     <= bi_nxt;
    ii_r     <= ii_nxt;
    bestbi_r <= bestbi_nxt;
    i_r      <= i_nxt;
    best_r   <= best_nxt;
    lim_r    <= lim_nxt;
    found_r  <= found_nxt;
    erase_r  <= erase_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // every entry sits in exactly one of queue and batch while idle; a release
  // grows the queue before it clears the batch
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (((CW + 1)'(fc_r) + (CW + 1)'(bc_r)) == (CW + 1)'(NUM_ENTRIES)))
    else $error("queue and batch counts do not add up to the entry count");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer still busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (i_r < v_r))
    else $error("compare index ran past the valid prefix");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP_WR) |-> (i_r < lim_r))
    else $error("ring copy ran past its limit");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.error_code != tpcm_pkg::ERR_NONE)) |->
      ((out_item.cached_count == '0) && (out_item.position == '0)))
    else $error("error result carries nonzero counts");

endmodule
`default_nettype wire

[rtl/tpcm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tpcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[tb/token_prefix_cache_matcher_tb.sv]
// Self-checking testbench of the token prefix cache matcher with its own prefix cache predictor.
`timescale 1ns / 1ps
module token_prefix_cache_matcher_tb;
  import tpcm_pkg::*;

  localparam int NUM_ENTRIES = 8;
  localparam int RING_TOKENS = 256;
  localparam int MAX_TOKENS  = 256;
  localparam int TOKEN_BITS  = 32;
  localparam int RANDOM_ITEMS = 860;
  localparam longint CYCLE_LIMIT = 40_000_000;

  // Predictor of the cache: entry rings, queue, batch and the request being loaded.
  // Every accepted transaction is noted; every result is checked against the oldest
  // expectation.
  class tpcm_scoreboard;
    logic [TOKEN_W-1:0] ring[NUM_ENTRIES][RING_TOKENS];
    bit                 present[NUM_ENTRIES];
    int unsigned        e_begin[NUM_ENTRIES];
    int unsigned        e_end[NUM_ENTRIES];
    int unsigned        e_fill[NUM_ENTRIES];
    logic [POS_W-1:0]   e_seq[NUM_ENTRIES];
    int unsigned        queue_order[NUM_ENTRIES];
    int unsigned        queue_cnt;
    int unsigned        batch[NUM_ENTRIES];
    int unsigned        batch_cnt;
    logic [TOKEN_W-1:0] req_ids[MAX_TOKENS];
    bit                 req_mask[MAX_TOKENS];
    int unsigned        req_len;
    bit                 req_ovf;
    tpcm_out_t          pending_results[$];
    int                 errors;

    function new();
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        present[k] = 0;
        queue_order[k] = k;
      end
      queue_cnt = NUM_ENTRIES;
      batch_cnt = 0;
      req_len = 0;
      req_ovf = 0;
      errors = 0;
    endfunction

    function int unsigned ring_dist(int unsigned from_i, int unsigned to_i);
      return (to_i % RING_TOKENS + RING_TOKENS - from_i % RING_TOKENS) % RING_TOKENS;
    endfunction

    function int unsigned held_len(int unsigned e);
      return ring_dist(e_begin[e], e_fill[e]);
    endfunction

    // Longest prefix of the request found in entry e at any ring start.
    function int unsigned longest_prefix(int unsigned e, int unsigned n,
                                         output int unsigned best_at);
      int unsigned best, bi, len, ii;
      best = 0;
      best_at = 0;
      if (!present[e]) return 0;
      bi = e_begin[e] % RING_TOKENS;
      for (int s = 0; s < RING_TOKENS; s++) begin
        len = 0;
        for (int i = 0; i < n; i++) begin
          if (!req_mask[i]) break;
          ii = (bi + i) % RING_TOKENS;
          if (ring[e][ii] !== req_ids[i]) break;
          len++;
          if (ii == e_end[e]) break;
        end
        if (len > best) begin
          best = len;
          best_at = bi;
        end
        if (bi == e_end[e]) break;
        bi = (bi + 1) % RING_TOKENS;
      end
      return best;
    endfunction

    // Move queue position p into the batch.
    function void take_from_queue(int unsigned p);
      int unsigned e;
      e = queue_order[p];
      for (int unsigned k = p; k + 1 < queue_cnt; k++) queue_order[k] = queue_order[k + 1];
      queue_cnt--;
      if (batch_cnt < NUM_ENTRIES) begin
        batch[batch_cnt] = e;
        batch_cnt++;
      end
    endfunction

    function void note_input(tpcm_in_t it);
      tpcm_out_t r;
      int unsigned n, v, trail, best, best_pos, best_at, at, len, e, cached, ii;
      bit found;
      r = '0;
      if (it.req_type == REQ_TOKEN) begin
        if (req_len < MAX_TOKENS) begin
          req_ids[req_len] = it.token_id;
          req_mask[req_len] = it.token_valid;
          req_len++;
        end else begin
          req_ovf = 1;
        end
        if (!it.last_token) return;
        n = req_len;
        req_len = 0;
        v = 0;
        while (v < n && req_mask[v]) v++;
        trail = 0;
        while (trail < n && !req_mask[n - 1 - trail]) trail++;
        r.result_kind = KIND_MATCH;
        if (req_ovf || v > RING_TOKENS) begin
          r.error_code = ERR_LONG;
        end else if (queue_cnt == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          best = 0;
          best_pos = 0;
          best_at = 0;
          found = 0;
          for (int unsigned k = 0; k < queue_cnt; k++) begin
            len = longest_prefix(queue_order[k], n, at);
            if (len > best) begin
              best = len;
              best_pos = k;
              best_at = at;
              found = 1;
            end
          end
          if (!found) begin
            // Replace the oldest queued entry with the valid prefix.
            e = queue_order[0];
            take_from_queue(0);
            present[e] = 1;
            e_begin[e] = 0;
            e_end[e] = 0;
            e_fill[e] = 0;
            e_seq[e] = '0;
            ring[e][0] = req_ids[0];
            for (int i = 1; i < n && i < RING_TOKENS; i++) begin
              if (!req_mask[i]) break;
              ring[e][i] = req_ids[i];
              e_end[e] = i;
            end
            cached = 0;
          end else begin
            // Append to the best entry from the matched start.
            e = queue_order[best_pos];
            take_from_queue(best_pos);
            e_seq[e] = e_seq[e] + ring_dist(e_begin[e], best_at);
            e_begin[e] = best_at;
            for (int unsigned i = 0; i < v; i++) begin
              ii = (best_at + i) % RING_TOKENS;
              ring[e][ii] = req_ids[i];
              e_end[e] = ii;
            end
            if (best < v) begin
              e_fill[e] = (best_at + best) % RING_TOKENS;
              cached = best;
            end else begin
              e_fill[e] = e_end[e];
              cached = best - 1;
            end
          end
          r.entry_index = e;
          r.cached_count = cached;
          r.uncached_count = (n >= cached + trail) ? n - cached - trail : 0;
          r.position = e_seq[e] + held_len(e);
        end
        req_ovf = 0;
      end else if (it.req_type == REQ_RELEASE || it.req_type == REQ_ERASE) begin
        r.result_kind = KIND_DONE;
        for (int unsigned k = 0; k < batch_cnt && queue_cnt < NUM_ENTRIES; k++) begin
          queue_order[queue_cnt] = batch[k];
          queue_cnt++;
        end
        batch_cnt = 0;
        if (it.req_type == REQ_ERASE)
          for (int k = 0; k < NUM_ENTRIES; k++) present[k] = 0;
      end else begin
        r.result_kind = KIND_POS;
        if (it.batch_slot >= batch_cnt) begin
          r.error_code = ERR_EMPTY;
        end else begin
          e = batch[it.batch_slot];
          r.entry_index = e;
          r.cached_count = held_len(e);
          r.position = e_seq[e] + held_len(e);
        end
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(tpcm_out_t got);
      tpcm_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.result_kind !== want.result_kind)
        $display("%0t: result_kind exp %0d got %0d", $realtime, want.result_kind,
                 got.result_kind);
      if (got.error_code !== want.error_code)
        $display("%0t: error_code exp %0d got %0d", $realtime, want.error_code,
                 got.error_code);
      if (got.entry_index !== want.entry_index)
        $display("%0t: entry_index exp %0d got %0d", $realtime, want.entry_index,
                 got.entry_index);
      if (got.cached_count !== want.cached_count)
        $display("%0t: cached_count exp %0d got %0d", $realtime, want.cached_count,
                 got.cached_count);
      if (got.uncached_count !== want.uncached_count)
        $display("%0t: uncached_count exp %0d got %0d", $realtime, want.uncached_count,
                 got.uncached_count);
      if (got.position !== want.position)
        $display("%0t: position exp %0h got %0h", $realtime, want.position, got.position);
      if (got !== want) errors++;
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  tpcm_in_t  in_item = '0;
  logic      out_valid;
  tpcm_out_t out_item;

  tpcm_scoreboard sb = new();
  longint    cycles = 0;
  int        idle_pct = 15;
  int        sent_items = 0;
  logic [TOKEN_W-1:0] recent_seqs[$][$];

  token_prefix_cache_matcher #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .RING_TOKENS(RING_TOKENS),
    .MAX_TOKENS (MAX_TOKENS),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Check results before noting a new transaction: a result never belongs to the
  // transaction taken at the same edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_input(in_item);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("token_prefix_cache_matcher_tb NOT OK");
      $finish;
    end
  end

  // Drop start and wait, k setting the wait; called right after a rising edge.
  task automatic hold_off(int k);
    start <= 1'b0;
    repeat (k) @(posedge clk);
  endtask

  // Present one transaction and return at the edge that takes it.
  task automatic send_item(tpcm_in_t it);
    if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 3));
    start <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent_items++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    hold_off(1);
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_control(logic [1:0] kind, int slot);
    tpcm_in_t it;
    it = {$urandom(), $urandom()};
    it.req_type = kind;
    it.batch_slot = slot;
    send_item(it);
  endtask

  // Send a whole request; ids and mask carry one position per transaction.
  task automatic send_request(logic [TOKEN_W-1:0] ids[$], bit mask[$]);
    tpcm_in_t it;
    for (int i = 0; i < ids.size(); i++) begin
      it.req_type = REQ_TOKEN;
      it.token_id = ids[i];
      it.token_valid = mask[i];
      it.last_token = (i == ids.size() - 1);
      it.batch_slot = $urandom();
      send_item(it);
    end
  endtask

  function automatic logic [TOKEN_W-1:0] pick_token();
    if ($urandom_range(99) < 85) return $urandom_range(0, 3);
    return $urandom();
  endfunction

  // Random request: often an old sequence's prefix extended, so entries get reused.
  task automatic random_request();
    logic [TOKEN_W-1:0] ids[$];
    bit mask[$];
    int len, cut, r;
    len = $urandom_range(1, 10);
    if (recent_seqs.size() > 0 && $urandom_range(99) < 65) begin
      ids = recent_seqs[$urandom_range(recent_seqs.size() - 1)];
      while (ids.size() > $urandom_range(1, ids.size())) void'(ids.pop_back());
    end
    while (ids.size() < len) ids.insert(ids.size(), pick_token());
    for (int i = 0; i < ids.size(); i++) mask.insert(mask.size(), 1'b1);
    r = $urandom_range(99);
    if (r < 12) begin
      cut = $urandom_range(0, ids.size() - 1);
      for (int i = cut; i < ids.size(); i++) mask[i] = 1'b0;
    end else if (r < 18) begin
      for (int i = 0; i < ids.size(); i++) mask[i] = $urandom_range(1);
    end
    recent_seqs.insert(recent_seqs.size(), ids);
    if (recent_seqs.size() > 16) recent_seqs.delete(0);
    send_request(ids, mask);
  endtask

  // Long requests: the full ring, and one token too many.
  task automatic long_request(int len, bit repeat_last);
    logic [TOKEN_W-1:0] ids[$];
    bit mask[$];
    for (int i = 0; i < len; i++) begin
      ids.insert(ids.size(), repeat_last ? 32'h5A5A_0000 + i : $urandom());
      mask.insert(mask.size(), 1'b1);
    end
    send_request(ids, mask);
  endtask

  initial begin
    logic [TOKEN_W-1:0] ids[$];
    bit mask[$];
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty batch, control with nothing to move, extreme tokens.
    idle_pct = 0;
    send_control(REQ_QUERY, 0);
    send_control(REQ_RELEASE, 7);
    send_control(REQ_ERASE, 3);
    ids = '{32'h0};             mask = '{1'b0};   send_request(ids, mask);
    ids = '{32'hFFFF_FFFF};     mask = '{1'b1};   send_request(ids, mask);
    ids = '{32'hFFFF_FFFF};     mask = '{1'b1};   send_request(ids, mask);
    ids = '{32'hFFFF_FFFF, 32'h1, 32'h2}; mask = '{1'b1, 1'b1, 1'b0};
    send_request(ids, mask);
    send_control(REQ_QUERY, 0);
    send_control(REQ_QUERY, 2);
    send_control(REQ_QUERY, 7);
    send_control(REQ_RELEASE, 0);
    ids = '{32'hFFFF_FFFF, 32'h1, 32'h3}; mask = '{1'b1, 1'b1, 1'b1};
    send_request(ids, mask);
    send_control(REQ_QUERY, 0);
    send_control(REQ_ERASE, 0);
    drain();

    // Random part in three sender idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
      while (sent_items < (ph + 1) * RANDOM_ITEMS / 3 + 40) begin
        r = $urandom_range(99);
        if (r < 72) random_request();
        else if (r < 82) send_control(REQ_RELEASE, $urandom());
        else if (r < 84) send_control(REQ_ERASE, $urandom());
        else send_control(REQ_QUERY, $urandom_range(0, 7));
      end
      // Full ring request, then the same again to match it whole, then overflow.
      if (ph == 2) begin
        send_control(REQ_RELEASE, 0);
        long_request(RING_TOKENS, 1'b1);
        send_control(REQ_RELEASE, 0);
        long_request(RING_TOKENS, 1'b1);
        long_request(MAX_TOKENS + 1, 1'b0);
        send_control(REQ_QUERY, 0);
      end
      drain();
    end

    hold_off(1);
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("token_prefix_cache_matcher_tb OK");
    end else begin
      $display("token_prefix_cache_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule
